[design/md5_pkg.sv]
// ============================================================================
// MD5 package
// Shared constants, types and round functions for the MD5 stream hasher.
// ============================================================================
package md5_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;

    // One queue entry: a classified byte item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } t_digest;

    function automatic logic [31:0] round_add(input logic [5:0] r);
        logic [31:0] k [64];
        k = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return k[r];
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s [16];
        s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
              5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
        return s[{r[5:4], r[1:0]}];
    endfunction

    // Word index of the message schedule for round r.
    function automatic logic [3:0] word_index(input logic [5:0] r);
        logic [3:0] g;
        case (r[5:4])
            2'd0:    g = r[3:0];
            2'd1:    g = 4'(5 * r[3:0] + 1);
            2'd2:    g = 4'(3 * r[3:0] + 5);
            default: g = 4'(7 * r[3:0]);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] round_mix(input logic [1:0] ph, input logic [31:0] b,
                                              input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (ph)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

[design/md5_if.sv]
// ============================================================================
// MD5 stream channels
// Valid/ready channels for input items and digest results.
// ============================================================================
interface md5_in_if;
    import md5_pkg::*;
    logic  valid;
    logic  ready;
    t_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface md5_out_if;
    import md5_pkg::*;
    logic    valid;
    logic    ready;
    t_digest payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[design/md5_ram.sv]
// ============================================================================
// MD5 generic RAM
// Single write port, single read port, registered read data.
// ============================================================================
module md5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/md5_front.sv]
// ============================================================================
// MD5 front end
// Accept items, drop empty non-last ones, and queue the rest.
// ============================================================================
module md5_front import md5_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    md5_in_if.sink   in_ch,
    output logic     o_q_valid,
    output t_item    o_q_item,
    input  logic     i_q_pop
);
    localparam int AW = $clog2(DEPTH);

    t_item           r_q [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            push, keep;

    assign in_ch.ready = (r_cnt != (AW+1)'(DEPTH));
    assign keep = in_ch.payload.has_byte | in_ch.payload.last;
    assign push = in_ch.valid & in_ch.ready & keep;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= AW'((32'(r_wp) + 1) % DEPTH);
            end
            if (i_q_pop) begin
                r_rp <= AW'((32'(r_rp) + 1) % DEPTH);
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(i_q_pop);
        end
        if (push) begin
            r_q[r_wp] <= in_ch.payload;
        end
    end
endmodule

[design/md5_back.sv]
// ============================================================================
// MD5 back end
// Buffer bytes, pad, run 64 rounds per block and emit the digest.
// ============================================================================
module md5_back import md5_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_item    i_q_item,
    output logic     o_q_pop,
    md5_out_if.source out_ch
);
    localparam logic [2:0] ST_FILL  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  r_st;
    logic [5:0]  r_fill;
    logic [63:0] r_total;
    logic        r_fin;      // closing in progress
    logic        r_lenph;    // writing length bytes
    logic        r_pend;     // close pending
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [6:0]  r_rnd;      // load/round counter
    logic [31:0] r_w [16];
    logic        r_ovalid;
    t_digest     r_dig;

    logic        we;
    logic [5:0]  waddr, raddr;
    logic [7:0]  wdata, rdata;
    logic [63:0] bits;
    logic [31:0] f, sum, rot, wg;
    logic [5:0]  rr;
    logic [4:0]  sh;

    md5_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_buf (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign bits = {r_total[60:0], 3'b000};
    assign o_q_pop = (r_st == ST_FILL) & i_q_valid;
    assign waddr = r_fill;
    assign raddr = r_rnd[5:0];

    always_comb begin
        we = 1'b0;
        wdata = i_q_item.data_byte;
        if (r_st == ST_FILL && i_q_valid && i_q_item.has_byte) begin
            we = 1'b1;
        end else if (r_st == ST_PAD) begin
            we = 1'b1;
            if (!r_fin) begin
                wdata = PAD_BYTE;
            end else if (r_lenph) begin
                wdata = bits[8*(r_fill[2:0]) +: 8];
            end else begin
                wdata = 8'h00;
            end
        end
    end

    assign rr  = r_rnd[5:0];
    assign f   = round_mix(rr[5:4], r_b, r_c, r_d);
    assign wg  = r_w[word_index(rr)];
    assign sum = r_a + f + round_add(rr) + wg;
    assign sh  = rot_amount(rr);
    assign rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_FILL;
            r_fill <= '0;
            r_total <= '0;
            r_fin <= 1'b0;
            r_lenph <= 1'b0;
            r_pend <= 1'b0;
            r_rnd <= '0;
            r_ovalid <= 1'b0;
            r_h[0] <= INIT_A; r_h[1] <= INIT_B;
            r_h[2] <= INIT_C; r_h[3] <= INIT_D;
        end else begin
            if (r_ovalid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                ST_FILL: begin
                    if (i_q_valid) begin
                        if (i_q_item.has_byte) begin
                            r_total <= r_total + 64'd1;
                            r_fill <= r_fill + 6'd1;
                        end
                        if (i_q_item.last) begin
                            r_st <= ST_PAD;
                            // the last byte may complete a block first
                            r_fin <= 1'b0;
                            r_pend <= 1'b1;
                        end
                        if (i_q_item.has_byte && r_fill == 6'd63) begin
                            r_st <= ST_LOAD;
                            r_rnd <= '0;
                        end
                    end
                end
                ST_PAD: begin
                    // first step writes 0x80; then zeros to 56, then length
                    r_fin <= 1'b1;
                    if (r_fill == 6'd55) r_lenph <= 1'b1;
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) begin
                        r_st <= ST_LOAD;
                        r_rnd <= '0;
                    end
                end
                ST_LOAD: begin
                    // read data is registered: data for address n arrives while the counter holds n+1
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd != 7'd0) begin
                        r_w[r_rnd[5:2] - 4'(r_rnd[1:0] == 2'd0)]
                            [8*(2'(r_rnd[1:0] - 2'd1)) +: 8] <= rdata;
                    end
                    if (r_rnd == 7'd64) begin
                        r_st <= ST_ROUND;
                        r_rnd <= '0;
                        r_a <= r_h[0]; r_b <= r_h[1];
                        r_c <= r_h[2]; r_d <= r_h[3];
                    end
                end
                ST_ROUND: begin
                    r_a <= r_d; r_d <= r_c; r_c <= r_b;
                    r_b <= r_b + rot;
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == 7'd63) r_st <= ST_ADD;
                end
                ST_ADD: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                    if (r_lenph) begin
                        r_st <= ST_OUT;         // length block done
                    end else if (r_pend) begin
                        r_st <= ST_PAD;         // close pending after full block
                    end else begin
                        r_st <= ST_FILL;        // plain full block
                    end
                end
                default: begin  // ST_OUT
                    if (!r_ovalid || out_ch.ready) begin
                        r_ovalid <= 1'b1;
                        r_dig <= '{r_h[0], r_h[1], r_h[2], r_h[3]};
                        r_h[0] <= INIT_A; r_h[1] <= INIT_B;
                        r_h[2] <= INIT_C; r_h[3] <= INIT_D;
                        r_total <= '0;
                        r_fill <= '0;
                        r_fin <= 1'b0;
                        r_lenph <= 1'b0;
                        r_pend <= 1'b0;
                        r_st <= ST_FILL;
                    end
                end
            endcase
        end
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.payload = r_dig;
endmodule

[design/md5_stream_hasher_core.sv]
// ============================================================================
// MD5 stream hasher core
// Byte-serial MD5 digest engine with a queued front end and a block engine.
// ============================================================================
//
//  channel   | dir | payload                              | handshake
//  ----------+-----+--------------------------------------+-------------
//  in_ch     | in  | data_byte[7:0], has_byte, last       | valid/ready
//  out_ch    | out | digest word0..word3, 32 bits each    | valid/ready
//
//  Each popped byte goes into the block buffer; a byte that completes a
//  64-byte block holds the back end while the block is read back, run through
//  the rounds and added into the chaining words (one round per cycle through
//  a single round unit). Closing writes the padding at one byte per cycle and
//  runs one or two more blocks before the digest is shown. The four-entry
//  queue takes items until full while the back end is busy. Reset is
//  synchronous, active low, and restores the MD5 initial chaining words.
//
module md5_stream_hasher_core import md5_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    md5_in_if.sink    in_ch,
    md5_out_if.source out_ch
);
    logic  q_valid, q_pop;
    t_item q_item;

    // Front: accept and queue transactions.
    md5_front #(.DEPTH(QDEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    // Back: buffer, pad, compress, deliver.
    md5_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid),
        .i_q_item(q_item), .o_q_pop(q_pop), .out_ch(out_ch)
    );

`ifndef NO_ASSERTIONS
    // A queue pop needs something in the queue.
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");

    // A shown digest stays until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
        else $error("digest dropped");
`endif
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// MD5 stream hasher testbench
// Sends byte messages through the input channel and checks each digest
// against an in-bench MD5 predictor; random bursts, gaps and output stalls.
// ============================================================================
module tb;
    import md5_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    md5_in_if  in_ch ();
    md5_out_if out_ch ();

    md5_stream_hasher_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: chaining words, block buffer, fill and byte count
    // ------------------------------------------------------------------
    logic [31:0] chain_q [4];
    logic [7:0]  blk_buf [64];
    logic [5:0]  fill_q;
    logic [63:0] msg_len_q;
    t_digest     digest_q [$];

    int n_items, n_digests, n_errors, n_cycles;

    localparam logic [31:0] SINE_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    localparam int SHIFT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                      4, 11, 16, 23, 6, 10, 15, 21};

    function automatic void md5_init();
        chain_q[0] = INIT_A;
        chain_q[1] = INIT_B;
        chain_q[2] = INIT_C;
        chain_q[3] = INIT_D;
        fill_q     = '0;
        msg_len_q  = '0;
    endfunction

    // Fold the full buffer into the chaining words.
    function automatic void md5_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t, s;
        int g, ph;
        for (int k = 0; k < 16; k++)
            w[k] = {blk_buf[4*k+3], blk_buf[4*k+2], blk_buf[4*k+1], blk_buf[4*k]};
        a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
        for (int r = 0; r < 64; r++) begin
            ph = r / 16;
            case (ph)
                0: begin f = (b & c) | (~b & d); g = r; end
                1: begin f = (d & b) | (~d & c); g = (5 * r + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
            endcase
            s = a + f + SINE_TAB[r] + w[g];
            t = d; d = c; c = b;
            b = b + ((s << SHIFT_TAB[ph*4 + r%4]) | (s >> (32 - SHIFT_TAB[ph*4 + r%4])));
            a = t;
        end
        chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
    endfunction

    function automatic void md5_absorb(logic [7:0] b);
        blk_buf[fill_q] = b;
        if (fill_q == 6'd63) md5_compress();
        fill_q = fill_q + 6'd1;
    endfunction

    // Advance the predictor by one transaction; queue a digest on last.
    function automatic void md5_predict(t_item it);
        logic [63:0] bits;
        t_digest dg;
        if (it.has_byte) begin
            md5_absorb(it.data_byte);
            msg_len_q = msg_len_q + 64'd1;
        end
        if (!it.last) return;
        bits = msg_len_q << 3;
        md5_absorb(PAD_BYTE);
        while (fill_q != LEN_POS) md5_absorb(8'h00);
        for (int k = 0; k < 8; k++) md5_absorb(bits[8*k +: 8]);
        dg.w0 = chain_q[0]; dg.w1 = chain_q[1]; dg.w2 = chain_q[2]; dg.w3 = chain_q[3];
        digest_q.push_back(dg);
        md5_init();
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_byte(logic [7:0] b, logic hb, logic lst);
        t_item it;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        it.data_byte = b; it.has_byte = hb; it.last = lst;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        md5_predict(it);
        n_items++;
        burst_left--;
    endtask

    task automatic drop_valid();
        in_ch.valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic send_message(int len, int fill_mode);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            case (fill_mode)
                0: b = 8'h00;
                1: b = 8'hff;
                default: b = 8'($urandom);
            endcase
            // Sprinkle byte-less filler transactions inside some messages.
            if (fill_mode == 3 && $urandom_range(0, 15) == 0)
                send_byte(8'($urandom), 1'b0, 1'b0);
            send_byte(b, 1'b1, k == len - 1);
        end
        if (len == 0) send_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    // Hold the sender until every pending digest has come back.
    task automatic wait_drain();
        drop_valid();
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, with stall-free stretches
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else if ((n_cycles / 500) % 4 == 1) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // Compare each accepted digest with the oldest prediction.
    always @(posedge i_clk) begin
        t_digest exp_d;
        n_cycles <= n_cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_digests++;
            if (digest_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("ERROR: unexpected digest %h", out_ch.payload);
            end else begin
                exp_d = digest_q.pop_front();
                if (out_ch.payload !== exp_d) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: digest mismatch exp %h act %h", exp_d, out_ch.payload);
                end
            end
        end
        if (n_cycles >= LIMIT_CYCLES) begin
            $display("ERROR: timeout with %0d digests pending", digest_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_message(0, 2);              // empty message
        send_byte(8'h61, 1'b1, 1'b1);    // "a": byte and close in one transaction
        send_byte(8'h12, 1'b0, 1'b0);    // filler before a message changes nothing
        send_message(55, 0);             // padding fits in one block
        send_message(56, 1);             // padding spills into a second block
        send_message(64, 2);             // exactly one block
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);    // close with no byte
        send_message(3, 1);
    endtask

    task automatic test_random_messages(int n_msgs);
        int len;
        for (int m = 0; m < n_msgs; m++) begin
            case ($urandom_range(0, 7))
                0: len = $urandom_range(0, 2);
                1: len = $urandom_range(54, 66);
                2: len = $urandom_range(118, 130);
                default: len = $urandom_range(1, 40);
            endcase
            send_message(len, $urandom_range(0, 9) < 2 ? $urandom_range(0, 1) : 3);
        end
    endtask

    initial begin
        n_items = 0; n_digests = 0; n_errors = 0; n_cycles = 0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        md5_init();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        wait_drain();
        test_random_messages(22);
        wait_drain();
        test_random_messages(22);
        drop_valid();
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("tb: %0d transactions sent, %0d digests checked", n_items, n_digests);
        $display("tb: messages of 0..130 bytes, padding edges, byte-less closes");
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", n_errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
